FILE: src/r3339_pkg.sv
// package for the rfc3339 timestamp parser
// types, phase codes and field widths shared by front end and date unit
`timescale 1ns / 1ps
package r3339_pkg;

    localparam int TimeW = 39;
    localparam int QueueDepthDef = 2;

    typedef enum logic [4:0] {
        P_YEAR, P_DASH1, P_MONTH, P_DASH2, P_DAY, P_SEP, P_HOUR, P_COLON1,
        P_MIN, P_COLON2, P_SEC, P_DOT, P_FRAC, P_ZHOUR, P_ZCOLON, P_ZMIN, P_DONE
    } phase_t;

    // one parsed timestamp handed from front end to date unit
    typedef struct packed {
        logic        good;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  zhour;
        logic [6:0]  zminute;
        logic        east;
    } stamp_t;

    typedef enum logic [2:0] {
        D_IDLE, D_ERA, D_DAYS, D_SECS, D_OUT
    } dstate_t;

endpackage

FILE: src/r3339_front.sv
// character front end: trims whitespace, walks the grammar, collects fields
// depends on r3339_pkg
`timescale 1ns / 1ps
module r3339_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          ch,
    input  logic                last,
    input  logic                take,
    output logic                done,
    output r3339_pkg::stamp_t   stamp
);
    r3339_pkg::phase_t phase_reg, phase_next;
    logic [4:0] kept_reg, kept_next, blank_reg, blank_next;
    logic [1:0] slot_reg, slot_next;
    logic [13:0] year_reg, year_next;
    logic [6:0] mon_reg, mon_next, day_reg, day_next, hr_reg, hr_next;
    logic [6:0] min_reg, min_next, sec_reg, sec_next, zh_reg, zh_next, zm_reg, zm_next;
    logic east_reg, east_next, fail_reg, fail_next;
    logic blank, digit;
    logic [3:0] dv;
    logic [5:0] ksum;

    function automatic logic [4:0] sat5(input logic [5:0] v);
        return (v > 6'd31) ? 5'd31 : v[4:0];
    endfunction

    assign blank = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    assign digit = (ch >= 8'd48 && ch <= 8'd57);
    assign dv    = ch[3:0];

    always_comb begin
        phase_next = phase_reg; kept_next = kept_reg; blank_next = blank_reg;
        slot_next = slot_reg; year_next = year_reg; mon_next = mon_reg;
        day_next = day_reg; hr_next = hr_reg; min_next = min_reg; sec_next = sec_reg;
        zh_next = zh_reg; zm_next = zm_reg; east_next = east_reg; fail_next = fail_reg;
        ksum = 6'd0;
        if (blank) begin
            if (kept_reg != 5'd0) blank_next = sat5({1'b0, blank_reg} + 6'd1);
        end else begin
            if (blank_reg != 5'd0) begin
                if (phase_reg == r3339_pkg::P_SEP && blank_reg == 5'd1)
                    phase_next = r3339_pkg::P_HOUR;
                else if (phase_reg != r3339_pkg::P_DONE) fail_next = 1'b1;
                blank_next = 5'd0;
            end
            ksum = {1'b0, kept_reg} + {1'b0, blank_reg};
            kept_next = sat5({1'b0, sat5(ksum)} + 6'd1);
            if (!fail_next) begin
                unique case (phase_next)
                    r3339_pkg::P_YEAR: begin
                        if (!digit) fail_next = 1'b1;
                        else begin
                            year_next = 14'(year_reg * 10) + 14'(dv);
                            slot_next = slot_reg + 2'd1;
                            if (slot_reg == 2'd3) phase_next = r3339_pkg::P_DASH1;
                        end
                    end
                    r3339_pkg::P_MONTH, r3339_pkg::P_DAY, r3339_pkg::P_HOUR,
                    r3339_pkg::P_MIN, r3339_pkg::P_SEC, r3339_pkg::P_ZHOUR,
                    r3339_pkg::P_ZMIN, r3339_pkg::P_ZCOLON: begin
                        if (phase_next == r3339_pkg::P_ZCOLON && ch == ":")
                            phase_next = r3339_pkg::P_ZMIN;
                        else if (!digit) begin
                            fail_next = 1'b1;
                            if (phase_next == r3339_pkg::P_ZCOLON)
                                phase_next = r3339_pkg::P_ZMIN;
                        end else begin
                            slot_next = (phase_next == r3339_pkg::P_ZCOLON) ? 2'd0 :
                                        slot_reg + 2'd1;
                            unique case (phase_next)
                                r3339_pkg::P_MONTH: mon_next = 7'(mon_reg * 10) + 7'(dv);
                                r3339_pkg::P_DAY:   day_next = 7'(day_reg * 10) + 7'(dv);
                                r3339_pkg::P_HOUR:  hr_next  = 7'(hr_reg * 10) + 7'(dv);
                                r3339_pkg::P_MIN:   min_next = 7'(min_reg * 10) + 7'(dv);
                                r3339_pkg::P_SEC:   sec_next = 7'(sec_reg * 10) + 7'(dv);
                                r3339_pkg::P_ZHOUR: zh_next  = 7'(zh_reg * 10) + 7'(dv);
                                default:            zm_next  = 7'(zm_reg * 10) + 7'(dv);
                            endcase
                            if (phase_next == r3339_pkg::P_ZCOLON) begin
                                slot_next = 2'd1;
                                phase_next = r3339_pkg::P_ZMIN;
                            end else if (slot_reg == 2'd1) begin
                                slot_next = 2'd0;
                                phase_next = r3339_pkg::phase_t'(phase_next + 5'd1);
                                if (phase_reg == r3339_pkg::P_ZMIN ||
                                    phase_next == r3339_pkg::P_ZMIN)
                                    phase_next = r3339_pkg::P_DONE;
                            end
                        end
                    end
                    r3339_pkg::P_DASH1, r3339_pkg::P_DASH2: begin
                        if (ch == "-") phase_next = r3339_pkg::phase_t'(phase_next + 5'd1);
                        else fail_next = 1'b1;
                    end
                    r3339_pkg::P_COLON1, r3339_pkg::P_COLON2: begin
                        if (ch == ":") phase_next = r3339_pkg::phase_t'(phase_next + 5'd1);
                        else fail_next = 1'b1;
                    end
                    r3339_pkg::P_SEP: begin
                        if (ch == "T" || ch == "t" || ch == " ") phase_next = r3339_pkg::P_HOUR;
                        else fail_next = 1'b1;
                    end
                    r3339_pkg::P_DOT, r3339_pkg::P_FRAC: begin
                        if (phase_next == r3339_pkg::P_DOT && ch == ".")
                            phase_next = r3339_pkg::P_FRAC;
                        else if (phase_next == r3339_pkg::P_FRAC && digit) begin
                        end else if (ch == "Z" || ch == "z") phase_next = r3339_pkg::P_DONE;
                        else if (ch == "+" || ch == "-") begin
                            east_next = (ch == "+");
                            slot_next = 2'd0;
                            phase_next = r3339_pkg::P_ZHOUR;
                        end else fail_next = 1'b1;
                    end
                    r3339_pkg::P_DONE: ;
                    default: fail_next = 1'b1;
                endcase
            end
        end
    end

    // result of this character when it is the last one
    always_comb begin
        stamp.good = !fail_next && kept_next >= 5'd20 &&
                     (phase_next == r3339_pkg::P_FRAC || phase_next == r3339_pkg::P_DONE) &&
                     mon_next >= 7'd1 && mon_next <= 7'd12 &&
                     day_next >= 7'd1 && day_next <= 7'd31 &&
                     hr_next <= 7'd23 && min_next <= 7'd59 && sec_next <= 7'd60;
        stamp.year = year_next; stamp.month = mon_next; stamp.day = day_next;
        stamp.hour = hr_next; stamp.minute = min_next; stamp.second = sec_next;
        stamp.zhour = zh_next; stamp.zminute = zm_next; stamp.east = east_next;
    end
    assign done = take && last;

    always_ff @(posedge aclk) begin
        if (!aresetn || done) begin
            phase_reg <= r3339_pkg::P_YEAR; kept_reg <= '0; blank_reg <= '0;
            slot_reg <= '0; year_reg <= '0; mon_reg <= '0; day_reg <= '0;
            hr_reg <= '0; min_reg <= '0; sec_reg <= '0; zh_reg <= '0; zm_reg <= '0;
            east_reg <= 1'b0; fail_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next; kept_reg <= kept_next; blank_reg <= blank_next;
            slot_reg <= slot_next; year_reg <= year_next; mon_reg <= mon_next;
            day_reg <= day_next; hr_reg <= hr_next; min_reg <= min_next;
            sec_reg <= sec_next; zh_reg <= zh_next; zm_reg <= zm_next;
            east_reg <= east_next; fail_reg <= fail_next;
        end
    end
endmodule

FILE: src/r3339_queue.sv
// small fifo of parsed timestamps between front end and date unit
// depends on r3339_pkg
`timescale 1ns / 1ps
module r3339_queue #(
    parameter int Depth = r3339_pkg::QueueDepthDef
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  r3339_pkg::stamp_t wr_data,
    output logic              full,
    output logic              empty,
    input  logic              rd_en,
    output r3339_pkg::stamp_t rd_data
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    r3339_pkg::stamp_t mem [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(Depth));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en) rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule

FILE: src/r3339_date.sv
// date unit: days-from-civil and offset, in registered steps per stamp
// depends on r3339_pkg
`timescale 1ns / 1ps
module r3339_date (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  r3339_pkg::stamp_t        in_stamp,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [r3339_pkg::TimeW-1:0] out_time,
    output logic                     out_ok
);
    r3339_pkg::dstate_t st_reg, st_next;
    r3339_pkg::stamp_t  s_reg;
    logic [4:0]  era_reg;
    logic [8:0]  yoe_reg, doy_reg;
    logic signed [23:0] days_reg;
    logic signed [r3339_pkg::TimeW-1:0] tod_reg, time_reg;
    logic signed [23:0] days_c;
    logic [14:0] y;
    logic [9:0]  y16;
    logic [15:0] era_p;
    logic [4:0]  era;
    logic [8:0]  yoe;
    logic [3:0]  mp;
    logic [11:0] doy_num;
    logic [22:0] doy_p;
    logic [8:0]  doy;
    logic [6:0]  yq4;
    logic [12:0] cent_p;
    logic [2:0]  cent;
    logic [17:0] doe;
    logic signed [r3339_pkg::TimeW-1:0] off, tod_c;

    // first step: era, year of era, day of year, time of day
    // divisions by 400 and 5 done as reciprocal multiplies
    always_comb begin
        y     = 15'(s_reg.year) + 15'd400 - ((s_reg.month <= 7'd2) ? 15'd1 : 15'd0);
        y16   = 10'(y >> 4);
        era_p = 16'(y16) * 16'd41;
        era   = 5'(era_p >> 10);
        yoe   = 9'(y - 15'(era) * 15'd400);
        mp    = (s_reg.month > 7'd2) ? 4'(s_reg.month - 7'd3) : 4'(s_reg.month + 7'd9);
        doy_num = 12'd153 * 12'(mp) + 12'd2;
        doy_p = 23'(doy_num) * 23'd3277;
        doy   = 9'(doy_p >> 14) + 9'(s_reg.day) - 9'd1;
        off  = r3339_pkg::TimeW'(s_reg.zhour) * 3600 + r3339_pkg::TimeW'(s_reg.zminute) * 60;
        tod_c = r3339_pkg::TimeW'(s_reg.hour) * 3600 + r3339_pkg::TimeW'(s_reg.minute) * 60
              + r3339_pkg::TimeW'(s_reg.second);
        tod_c = s_reg.east ? tod_c - off : tod_c + off;
    end

    // second step: day of era and day number
    always_comb begin
        yq4    = 7'(yoe_reg >> 2);
        cent_p = 13'(yq4) * 13'd41;
        cent   = 3'(cent_p >> 10);
        doe    = 18'(yoe_reg) * 18'd365 + 18'(yq4) - 18'(cent) + 18'(doy_reg);
        days_c = 24'(era_reg) * 24'sd146097 + 24'(doe) - 24'sd719468 - 24'sd146097;
    end

    always_comb begin
        st_next = st_reg;
        in_ready = 1'b0;
        unique case (st_reg)
            r3339_pkg::D_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) st_next = r3339_pkg::D_ERA;
            end
            r3339_pkg::D_ERA:  st_next = r3339_pkg::D_DAYS;
            r3339_pkg::D_DAYS: st_next = r3339_pkg::D_SECS;
            r3339_pkg::D_SECS: st_next = r3339_pkg::D_OUT;
            r3339_pkg::D_OUT: if (out_ready) st_next = r3339_pkg::D_IDLE;
            default: st_next = r3339_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= r3339_pkg::D_IDLE;
        else st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        if (st_reg == r3339_pkg::D_IDLE) s_reg <= in_stamp;
        if (st_reg == r3339_pkg::D_ERA) begin
            era_reg <= era;
            yoe_reg <= yoe;
            doy_reg <= doy;
            tod_reg <= tod_c;
        end
        if (st_reg == r3339_pkg::D_DAYS) days_reg <= days_c;
        if (st_reg == r3339_pkg::D_SECS)
            time_reg <= s_reg.good ? r3339_pkg::TimeW'(days_reg) * 86400 + tod_reg : '0;
    end

    assign out_valid = (st_reg == r3339_pkg::D_OUT);
    assign out_time  = time_reg;
    assign out_ok    = s_reg.good;
endmodule

FILE: src/rfc3339_timestamp_to_unix_seconds_top.sv
// top level of the rfc3339 timestamp to unix seconds converter
// depends on r3339_pkg, r3339_front, r3339_queue, r3339_date
`timescale 1ns / 1ps
// usage:
// - s_ channel takes one character per request; tlast marks the final one
// - every request with tlast high yields one m_ request: unix seconds in tdata,
//   ok flag in tuser
// - front end takes a character every cycle, so s_axis_tready stays high
//   except when the stamp queue is full and a final character arrives
// - the date unit takes a parsed stamp, splits the date into era and day of
//   year, then forms the day number, then the full seconds, registering each
//   step, and then presents the result
// - the date unit takes no new stamp until its result is taken; characters
//   flow on into the front end, buffered by a queue of QueueDepth stamps
// - a stalled m_ side holds the result; the queue absorbs later stamps and
//   then back-pressures only on final characters
// - a rejected text gives zero seconds with ok low
// - synchronous reset empties the queue and returns the parser to the start
module rfc3339_timestamp_to_unix_seconds_top #(
    parameter int QueueDepth = r3339_pkg::QueueDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // unix_time[38:0], zero pad
    output logic        m_axis_tuser    // ok
);
    r3339_pkg::stamp_t stamp_w, q_out;
    logic done, full, empty, d_ready, take, ok;
    logic [r3339_pkg::TimeW-1:0] t;

    // only final characters push into the queue
    assign s_axis_tready = !(full && s_axis_tlast);
    assign take = s_axis_tvalid && s_axis_tready;

    r3339_front u_front (
        .aclk(aclk), .aresetn(aresetn), .ch(s_axis_tdata), .last(s_axis_tlast),
        .take(take), .done(done), .stamp(stamp_w)
    );

    r3339_queue #(.Depth(QueueDepth)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(done), .wr_data(stamp_w),
        .full(full), .empty(empty), .rd_en(d_ready && !empty), .rd_data(q_out)
    );

    r3339_date u_date (
        .aclk(aclk), .aresetn(aresetn), .in_valid(!empty), .in_stamp(q_out),
        .in_ready(d_ready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_time(t), .out_ok(ok)
    );

    assign m_axis_tdata = {1'b0, t};
    assign m_axis_tuser = ok;
endmodule

FILE: verif/rfc3339_timestamp_to_unix_seconds_top_test.sv
// self-checking testbench for the rfc3339 timestamp to unix seconds converter
// streams characters through dut, predicts every result in-line, compares fields
// depends on r3339_pkg and rfc3339_timestamp_to_unix_seconds_top
`timescale 1ns / 1ps
module rfc3339_timestamp_to_unix_seconds_top_test;

    // one character request as queued for the driver
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;   // wait until every pending result is back first
    } char_req_t;

    // one converted timestamp as seen on the result side
    typedef struct {
        logic [38:0] secs;
        logic        ok;
    } stamp_result_t;

    localparam int StallLimit = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // ch
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;             // unix_time[38:0], zero pad
    logic        m_axis_tuser;             // ok

    char_req_t     char_q[$];
    stamp_result_t result_q[$];
    int            error_count = 0;
    int            chars_sent = 0;
    int            stamps_checked = 0;
    int            stamps_good = 0;
    int            idle_cycles = 0;
    int            gen_chars = 0;

    // parser shadow state
    r3339_pkg::phase_t ps_phase;
    int          ps_kept, ps_blanks, ps_slot;
    int          ps_year, ps_month, ps_day, ps_hour, ps_min, ps_sec, ps_zh, ps_zm;
    bit          ps_east, ps_failed;

    always #4 aclk = ~aclk;

    rfc3339_timestamp_to_unix_seconds_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_axis_tvalid        (s_axis_tvalid),
        .s_axis_tready        (s_axis_tready),
        .s_axis_tdata         (s_axis_tdata),
        .s_axis_tlast         (s_axis_tlast),
        .m_axis_tvalid        (m_axis_tvalid),
        .m_axis_tready        (m_axis_tready),
        .m_axis_tdata         (m_axis_tdata),
        .m_axis_tuser         (m_axis_tuser)
    );

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_parser();
        ps_phase = r3339_pkg::P_YEAR;
        ps_kept = 0; ps_blanks = 0; ps_slot = 0;
        ps_year = 0; ps_month = 0; ps_day = 0; ps_hour = 0; ps_min = 0; ps_sec = 0;
        ps_zh = 0; ps_zm = 0; ps_east = 1'b0; ps_failed = 1'b0;
    endfunction

    // accumulate one digit of an n-digit field, advance when the field is full
    function automatic void eat_digit(logic [7:0] c, ref int acc, input int n,
                                      input r3339_pkg::phase_t nxt);
        if (!is_num(c)) begin
            ps_failed = 1'b1;
            return;
        end
        acc = acc * 10 + (c - "0");
        ps_slot = (ps_slot + 1) & 3;
        if (ps_slot == (n & 3)) begin
            ps_slot = 0;
            ps_phase = nxt;
        end
    endfunction

    function automatic void zone_begin(logic [7:0] c);
        if (c == "Z" || c == "z") begin
            ps_phase = r3339_pkg::P_DONE;
        end else if (c == "+" || c == "-") begin
            ps_east = (c == "+");
            ps_slot = 0;
            ps_phase = r3339_pkg::P_ZHOUR;
        end else begin
            ps_failed = 1'b1;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (ps_phase)
            r3339_pkg::P_YEAR:   eat_digit(c, ps_year, 4, r3339_pkg::P_DASH1);
            r3339_pkg::P_DASH1:  if (c == "-") ps_phase = r3339_pkg::P_MONTH;
                                 else ps_failed = 1'b1;
            r3339_pkg::P_MONTH:  eat_digit(c, ps_month, 2, r3339_pkg::P_DASH2);
            r3339_pkg::P_DASH2:  if (c == "-") ps_phase = r3339_pkg::P_DAY;
                                 else ps_failed = 1'b1;
            r3339_pkg::P_DAY:    eat_digit(c, ps_day, 2, r3339_pkg::P_SEP);
            r3339_pkg::P_SEP:    if (c == "T" || c == "t" || c == " ")
                                     ps_phase = r3339_pkg::P_HOUR;
                                 else ps_failed = 1'b1;
            r3339_pkg::P_HOUR:   eat_digit(c, ps_hour, 2, r3339_pkg::P_COLON1);
            r3339_pkg::P_COLON1: if (c == ":") ps_phase = r3339_pkg::P_MIN;
                                 else ps_failed = 1'b1;
            r3339_pkg::P_MIN:    eat_digit(c, ps_min, 2, r3339_pkg::P_COLON2);
            r3339_pkg::P_COLON2: if (c == ":") ps_phase = r3339_pkg::P_SEC;
                                 else ps_failed = 1'b1;
            r3339_pkg::P_SEC:    eat_digit(c, ps_sec, 2, r3339_pkg::P_DOT);
            r3339_pkg::P_DOT:    if (c == ".") ps_phase = r3339_pkg::P_FRAC;
                                 else zone_begin(c);
            r3339_pkg::P_FRAC:   if (!is_num(c)) zone_begin(c);
            r3339_pkg::P_ZHOUR:  eat_digit(c, ps_zh, 2, r3339_pkg::P_ZCOLON);
            r3339_pkg::P_ZCOLON: begin
                ps_phase = r3339_pkg::P_ZMIN;
                if (c != ":") eat_digit(c, ps_zm, 2, r3339_pkg::P_DONE);
            end
            r3339_pkg::P_ZMIN:   eat_digit(c, ps_zm, 2, r3339_pkg::P_DONE);
            r3339_pkg::P_DONE:   ;
            default:             ps_failed = 1'b1;
        endcase
    endfunction

    // days from civil date plus time of day, offset removed
    function automatic longint civil_seconds();
        longint mo, yr, era, yoe, mp, doy, doe, days, secs, off;
        mo = ps_month;
        yr = ps_year + 400 - (mo <= 2 ? 1 : 0);
        era = yr / 400;
        yoe = yr - era * 400;
        mp = mo > 2 ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + ps_day - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468 - 146097;
        secs = days * 86400 + longint'(ps_hour) * 3600 + ps_min * 60 + ps_sec;
        off = longint'(ps_zh) * 3600 + ps_zm * 60;
        return ps_east ? secs - off : secs + off;
    endfunction

    // advance the shadow parser by one accepted character
    function automatic void predict_char(logic [7:0] c, logic last);
        stamp_result_t r;
        bit good;
        longint t;
        if (is_ws(c)) begin
            if (ps_kept != 0) ps_blanks = (ps_blanks + 1 > 31) ? 31 : ps_blanks + 1;
        end else begin
            if (ps_blanks != 0) begin
                // a lone interior blank is only legal as the date-time separator or once the zone is complete
                if (ps_phase == r3339_pkg::P_SEP && ps_blanks == 1)
                    ps_phase = r3339_pkg::P_HOUR;
                else if (ps_phase != r3339_pkg::P_DONE) ps_failed = 1'b1;
                ps_kept = (ps_kept + ps_blanks > 31) ? 31 : ps_kept + ps_blanks;
                ps_blanks = 0;
            end
            ps_kept = (ps_kept + 1 > 31) ? 31 : ps_kept + 1;
            if (!ps_failed) parse_char(c);
        end
        if (!last) return;
        good = !ps_failed && ps_kept >= 20
            && (ps_phase == r3339_pkg::P_FRAC || ps_phase == r3339_pkg::P_DONE)
            && ps_month >= 1 && ps_month <= 12 && ps_day >= 1 && ps_day <= 31
            && ps_hour <= 23 && ps_min <= 59 && ps_sec <= 60;
        t = good ? civil_seconds() : 0;
        r.secs = t[38:0];
        r.ok = good;
        result_q.push_back(r);
        clear_parser();
    endfunction

    // queue a text built up in a byte queue
    task automatic queue_bytes(ref logic [7:0] txt[$], input bit hold);
        char_req_t r;
        for (int i = 0; i < txt.size(); i++) begin
            r.ch = txt[i];
            r.last = (i == txt.size() - 1);
            r.hold = hold && (i == 0);
            char_q.push_back(r);
        end
        gen_chars += txt.size();
    endtask

    task automatic queue_text(string s, bit hold = 1'b0);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        queue_bytes(txt, hold);
    endtask

    function automatic logic [7:0] any_ws();
        int k;
        k = $urandom_range(0, 5);
        return k == 5 ? 8'd32 : 8'(9 + k);
    endfunction

    function automatic void push_num(ref logic [7:0] txt[$], input int v, input int n);
        int d;
        d = 1;
        for (int i = 1; i < n; i++) d *= 10;
        for (int i = 0; i < n; i++) begin
            txt.push_back(8'("0" + (v / d) % 10));
            d /= 10;
        end
    endfunction

    // random field value: mostly legal, sometimes at or past the limits
    function automatic int pick(int lo, int hi);
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return lo;
        if (k == 1) return hi;
        if (k == 2) return $urandom_range(0, 99);
        return $urandom_range(lo, hi);
    endfunction

    // a well-formed timestamp with random content, optionally damaged
    task automatic queue_random_stamp();
        logic [7:0] txt[$];
        int k, pos;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) txt.push_back(any_ws());
        push_num(txt, $urandom_range(0, 3) == 0 ? $urandom_range(0, 9999)
                                              : $urandom_range(1900, 2100), 4);
        txt.push_back("-");
        push_num(txt, pick(1, 12), 2);
        txt.push_back("-");
        push_num(txt, pick(1, 31), 2);
        k = $urandom_range(0, 2);
        txt.push_back(k == 0 ? "T" : (k == 1 ? "t" : " "));
        push_num(txt, pick(0, 23), 2);
        txt.push_back(":");
        push_num(txt, pick(0, 59), 2);
        txt.push_back(":");
        push_num(txt, pick(0, 60), 2);
        if ($urandom_range(0, 2) == 0) begin
            txt.push_back(".");
            repeat ($urandom_range(0, 6)) txt.push_back(8'("0" + $urandom_range(0, 9)));
        end
        k = $urandom_range(0, 6);
        if (k <= 1) begin
            txt.push_back(k == 0 ? "Z" : "z");
        end else if (k <= 5) begin
            txt.push_back($urandom_range(0, 1) ? "+" : "-");
            push_num(txt, $urandom_range(0, 99), 2);
            if (k <= 3) txt.push_back(":");
            push_num(txt, $urandom_range(0, 99), 2);
        end
        // text after the zone is ignored, interior blanks included
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                txt.push_back($urandom_range(0, 1) ? any_ws() : 8'($urandom_range(33, 126)));
            end
            txt.push_back(8'($urandom_range(33, 126)));
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) txt.push_back(any_ws());
        // damage: swap in a raw byte, or cut the text short
        k = $urandom_range(0, 9);
        if (k == 0) begin
            pos = $urandom_range(0, txt.size() - 1);
            txt[pos] = 8'($urandom_range(0, 255));
        end else if (k == 1) begin
            pos = $urandom_range(1, txt.size() - 1);
            while (txt.size() > pos) void'(txt.pop_back());
        end
        queue_bytes(txt, 1'b0);
    endtask

    task automatic queue_noise();
        logic [7:0] txt[$];
        repeat ($urandom_range(1, 30)) txt.push_back(8'($urandom_range(0, 255)));
        queue_bytes(txt, 1'b0);
    endtask

    // driver: presents queued characters with a random gap before each
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    always @(posedge aclk) begin
        logic       nxt_valid;
        char_req_t  r;
        nxt_valid = s_axis_tvalid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_char(s_axis_tdata, s_axis_tlast);
                chars_sent++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 8);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (char_q.size() != 0 &&
                             (!char_q[0].hold || result_q.size() == 0)) begin
                    r = char_q.pop_front();
                    s_axis_tdata <= r.ch;
                    s_axis_tlast <= r.last;
                    nxt_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // monitor: random stalls on the result side, checks every result
    int  recv_stall = 0;
    bit  recv_burst = 1'b0;
    always @(posedge aclk) begin
        stamp_result_t exp_r;
        logic          nxt_ready;
        nxt_ready = 1'b0;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result secs=%0d ok=%0b", $time,
                             $signed(m_axis_tdata[38:0]), m_axis_tuser);
                    error_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    stamps_checked++;
                    if (exp_r.ok) stamps_good++;
                    if (m_axis_tdata[38:0] !== exp_r.secs) begin
                        $display("%0t: unix_time mismatch expected %0d actual %0d", $time,
                                 $signed(exp_r.secs), $signed(m_axis_tdata[38:0]));
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_r.ok) begin
                        $display("%0t: ok mismatch expected %0b actual %0b", $time,
                                 exp_r.ok, m_axis_tuser);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
            end
            if (recv_stall > 0) recv_stall--;
            else nxt_ready = 1'b1;
        end
        m_axis_tready <= nxt_ready;
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        clear_parser();
        // directed: range extremes, every separator and zone form, special cases
        queue_text("1970-01-01T00:00:00Z");
        queue_text("0000-01-01T00:00:00+99:99");
        queue_text("9999-12-31T23:59:60-99:99");
        queue_text("2000-02-29t12:34:56.789z");
        queue_text("2000-03-01 00:00:00+0530");
        queue_text("1969-12-31T23:59:59-0800");
        queue_text(" \t\n2024-06-15T08:30:00.5Z \r\n");   // leading and trailing blanks
        queue_text("2024-06-15T08:30:00.123");           // ends in fraction, no zone
        queue_text("2024-06-15T08:30:00.");               // ends right after the dot
        queue_text("2024-06-15T08:30:00");                // ends before zone
        queue_text("2024-06-15T08:30:0Z");                // short text
        queue_text("2024-06-15T08:30:00Z  trailing x");   // anything after the zone
        queue_text("2024-06-15  08:30:00Z");              // two interior blanks
        queue_text("2024-06-15T08: 30:00Z");              // blank in the wrong place
        queue_text("2024-13-15T08:30:00Z");               // month too big
        queue_text("2024-00-00T24:60:61Z");               // month, day and time fields out of range
        queue_text("2024-06-32T08:30:00Z");
        queue_text("2024-02-31T23:59:60+00:00", 1'b1);   // no month-length check
        queue_text("2024/06/15T08:30:00Z");
        queue_text("\v\f");                                // blanks only
        queue_text("Z");
        queue_text("2024-06-15T08:30:00+1:00");
        queue_text({"2024-06-15T08:30:00Z", " ", "a", " ", " ", "b"});
        while (gen_chars < 1250) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_random_stamp();
            if ($urandom_range(0, 40) == 0) char_q[char_q.size() - 1].hold = 1'b1;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(char_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0))
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("sent %0d characters; checked %0d timestamps (%0d accepted, %0d rejected)",
                 chars_sent, stamps_checked, stamps_good, stamps_checked - stamps_good);
        if (error_count == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
